// ===== hw/rtl/bifid_cipher_block_top_assert.svh =====
// assertion macros for the bifid cipher rtl, used by the block engine
`ifndef BIFID_CIPHER_BLOCK_TOP_ASSERT_SVH
`define BIFID_CIPHER_BLOCK_TOP_ASSERT_SVH

// condition must never be seen at a clock edge outside reset
`define BCB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BCB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define BCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bcb_pkg.sv =====
// types, constants and helpers shared by the bifid cipher rtl
package bcb_pkg;

  localparam int NUM_CELLS = 25;
  localparam int Q_DEPTH   = 2;

  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_GAP    = 8'h20;

  localparam logic [6:0] ASCII_A   = 7'h41;
  localparam logic [6:0] ASCII_Z   = 7'h5A;
  localparam logic [4:0] LAST_CODE = 5'd25;
  localparam logic [4:0] CODE_NONE = 5'd31;

  localparam logic [1:0] CFG_SQ_LOW  = 2'd0;
  localparam logic [1:0] CFG_SQ_MID  = 2'd1;
  localparam logic [1:0] CFG_SQ_HIGH = 2'd2;
  localparam logic [1:0] CFG_DIR     = 2'd3;

  // row and column of each cell, row major
  localparam logic [2:0] CELL_ROW [NUM_CELLS] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
  localparam logic [2:0] CELL_COL [NUM_CELLS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4};

  typedef logic [NUM_CELLS-1:0][4:0] square_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  typedef struct packed {
    logic letter_ok;
    pos_t pos;
    logic last;
  } qent_t;

  function automatic logic [6:0] code_to_ascii(input logic [4:0] code);
    logic [6:0] ch;
    if (code > LAST_CODE) begin
      ch = ASCII_Z;
    end else begin
      ch = ASCII_A + {2'b00, code};
    end
    return ch;
  endfunction

endpackage

// ===== hw/rtl/bcb_if.sv =====
// valid/ready channel interfaces for input bytes and output letters
interface bcb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       message_last;

  modport source (output valid, output char_byte, output message_last, input ready);
  modport sink (input valid, input char_byte, input message_last, output ready);
endinterface

interface bcb_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       block_end;
  logic       message_end;

  modport source (output valid, output out_char, output block_end, output message_end,
                  input ready);
  modport sink (input valid, input out_char, input block_end, input message_end,
                output ready);
endinterface

// ===== hw/rtl/bcb_front.sv =====
// front end: case folding and square lookup of each input byte
module bcb_front
  import bcb_pkg::*;
(
  bcb_in_if.sink    in_ch,
  input  square_t   square,
  output logic      push_v,
  input  logic      push_rdy,
  output qent_t     push_data
);

  logic [7:0] folded;
  logic [4:0] code;
  logic       is_letter;
  logic       found;
  logic [2:0] row;
  logic [2:0] col;

  always_comb begin
    folded = in_ch.char_byte;
    if (in_ch.char_byte >= CHR_LOWER_A && in_ch.char_byte <= CHR_LOWER_Z) begin
      folded = in_ch.char_byte - CASE_GAP;
    end
    is_letter = (folded >= CHR_UPPER_A) && (folded <= CHR_UPPER_Z);
    code      = 5'(folded - CHR_UPPER_A);
  end

  // descending scan so the lowest matching cell wins
  always_comb begin
    found = 1'b0;
    row   = '0;
    col   = '0;
    for (int i = NUM_CELLS - 1; i >= 0; i--) begin
      if (is_letter && square[i] == code) begin
        found = 1'b1;
        row   = CELL_ROW[i];
        col   = CELL_COL[i];
      end
    end
  end

  assign push_v              = in_ch.valid;
  assign in_ch.ready         = push_rdy;
  assign push_data.letter_ok = found;
  assign push_data.pos.row   = row;
  assign push_data.pos.col   = col;
  assign push_data.last      = in_ch.message_last;

endmodule

// ===== hw/rtl/bcb_queue.sv =====
// short fifo between the classifying front end and the block engine
module bcb_queue
  import bcb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_v,
  output logic  push_rdy,
  input  qent_t push_data,
  output logic  pop_v,
  input  logic  pop_rdy,
  output qent_t pop_data
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int NW = $clog2(Q_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(Q_DEPTH - 1);
  localparam logic [NW-1:0] FULL      = NW'(Q_DEPTH);

  qent_t         slot_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_rdy = (count_r != FULL);
  assign pop_v    = (count_r != '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign push     = push_v && push_rdy;
  assign pop      = pop_v && pop_rdy;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/bcb_back.sv =====
// block engine: buffers positions, fractionates and emits each block
`include "bifid_cipher_block_top_assert.svh"

module bcb_back
  import bcb_pkg::*;
#(
  parameter int BLOCK_LEN = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_v,
  output logic      pop_rdy,
  input  qent_t     pop_data,
  input  square_t   square,
  input  logic      dir,
  bcb_out_if.source out_ch
);

  localparam int AW = $clog2(BLOCK_LEN);
  localparam int CW = $clog2(BLOCK_LEN + 1);
  localparam int JW = CW + 1;
  localparam logic [CW-1:0] FULL = CW'(BLOCK_LEN);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } bstate_t;

  bstate_t       state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] emit_k_r, emit_k_nxt;
  logic [CW-1:0] emit_n_r, emit_n_nxt;
  logic          emit_last_r, emit_last_nxt;
  logic [CW-1:0] fill_inc, k_plus;
  logic          pop, we, issue, out_free, s1_adv, k_final;

  pos_t          mem [BLOCK_LEN];
  pos_t          rd0_r, rd1_r;
  logic [JW-1:0] j0, j1, d0, d1, nj, kj;
  logic [AW-1:0] a0, a1;
  logic          c0, c1;

  logic          s1_v_r, s1_c0_r, s1_c1_r, s1_bend_r, s1_mend_r;
  logic          out_v_r;
  logic [6:0]    out_char_r;
  logic          out_bend_r, out_mend_r;
  logic [2:0]    sel_row, sel_col;
  logic [4:0]    sq_idx, code;

  assign pop_rdy  = (state_r == ST_LOAD);
  assign pop      = pop_v && pop_rdy;
  assign we       = pop && pop_data.letter_ok;
  assign fill_inc = fill_r + CW'(we);
  assign out_free = !out_v_r || out_ch.ready;
  assign issue    = (state_r == ST_EMIT) && (!s1_v_r || out_free);
  assign s1_adv   = s1_v_r && out_free;
  assign k_plus   = emit_k_r + CW'(1);
  assign k_final  = (k_plus == emit_n_r);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    emit_k_nxt    = emit_k_r;
    emit_n_nxt    = emit_n_r;
    emit_last_nxt = emit_last_r;
    unique case (state_r)
      ST_LOAD: begin
        fill_nxt = fill_inc;
        if (pop && (fill_inc == FULL || (pop_data.last && fill_inc != '0))) begin
          state_nxt     = ST_EMIT;
          emit_n_nxt    = fill_inc;
          emit_k_nxt    = '0;
          emit_last_nxt = pop_data.last;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          emit_k_nxt = k_plus;
          if (k_final) begin
            state_nxt = ST_LOAD;
            fill_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      emit_k_r    <= '0;
      emit_n_r    <= '0;
      emit_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      emit_k_r    <= emit_k_nxt;
      emit_n_r    <= emit_n_nxt;
      emit_last_r <= emit_last_nxt;
    end
  end

  // two coordinates per output letter, each from its own read port
  always_comb begin
    nj = {1'b0, emit_n_r};
    kj = {1'b0, emit_k_r};
    d0 = '0;
    d1 = '0;
    if (!dir) begin
      // rows of the block, then columns, read in pairs
      j0 = {emit_k_r, 1'b0};
      j1 = j0 + JW'(1);
      if (j0 < nj) begin
        a0 = j0[AW-1:0];
        c0 = 1'b0;
      end else begin
        d0 = j0 - nj;
        a0 = d0[AW-1:0];
        c0 = 1'b1;
      end
      if (j1 < nj) begin
        a1 = j1[AW-1:0];
        c1 = 1'b0;
      end else begin
        d1 = j1 - nj;
        a1 = d1[AW-1:0];
        c1 = 1'b1;
      end
    end else begin
      // interleaved r0 c0 r1 c1 stream split in halves
      j0 = kj;
      j1 = nj + kj;
      a0 = j0[AW:1];
      c0 = j0[0];
      a1 = j1[AW:1];
      c1 = j1[0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[fill_r[AW-1:0]] <= pop_data.pos;
    end
    if (issue) begin
      rd0_r <= mem[a0];
      rd1_r <= mem[a1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (issue) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_c0_r   <= c0;
      s1_c1_r   <= c1;
      s1_bend_r <= k_final;
      s1_mend_r <= k_final && emit_last_r;
    end
  end

  always_comb begin
    sel_row = s1_c0_r ? rd0_r.col : rd0_r.row;
    sel_col = s1_c1_r ? rd1_r.col : rd1_r.row;
    sq_idx  = {sel_row, 2'b00} + {2'b00, sel_row} + {2'b00, sel_col};
    code    = (sq_idx < 5'(NUM_CELLS)) ? square[sq_idx] : CODE_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_char_r <= code_to_ascii(code);
      out_bend_r <= s1_bend_r;
      out_mend_r <= s1_mend_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.block_end   = out_bend_r;
  assign out_ch.message_end = out_mend_r;

  `BCB_ASSERT_NEVER(a_fill_bound, fill_r > FULL, "fill count beyond block length")
  `BCB_ASSERT_IMPLY(a_emit_range, state_r == ST_EMIT, emit_k_r < emit_n_r && emit_n_r != '0, "emit index out of block")
  `BCB_ASSERT_NEXT(a_s1_hold, s1_v_r && !out_free, s1_v_r && $stable(rd0_r) && $stable(rd1_r), "read stage lost data under stall")
  `BCB_ASSERT_IMPLY(a_no_write_emit, state_r == ST_EMIT, !we, "position write during emission")

endmodule

// ===== hw/rtl/bifid_cipher_block_top.sv =====
// bifid cipher top: key square registers, front end, queue and block engine
// order: a byte enters the queue on acceptance; once the block's closing item leaves the queue, the
//   engine enters its emit state and each letter passes the read stage and then the output register
// flow: bytes load one per cycle while the queue has room; the engine takes no bytes while a block emits,
//   and letters emit one per cycle through the two-port position memory unless the receiver stalls
// reset: synchronous active low, clears registers, queue and pipeline; positions are not cleared
module bifid_cipher_block_top
  import bcb_pkg::*;
#(
  parameter int BLOCK_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  bcb_in_if.sink      in_ch,
  bcb_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [49:0] cfg_data
);

  logic [49:0] sq_low_r;
  logic [49:0] sq_mid_r;
  logic [24:0] sq_high_r;
  logic        dir_r;
  square_t     square;

  logic  push_v, push_rdy, pop_v, pop_rdy;
  qent_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_low_r  <= '0;
      sq_mid_r  <= '0;
      sq_high_r <= '0;
      dir_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SQ_LOW:  sq_low_r  <= cfg_data;
        CFG_SQ_MID:  sq_mid_r  <= cfg_data;
        CFG_SQ_HIGH: sq_high_r <= cfg_data[24:0];
        CFG_DIR:     dir_r     <= cfg_data[0];
        default: begin
          dir_r <= dir_r;
        end
      endcase
    end
  end

  assign square = {sq_high_r, sq_mid_r, sq_low_r};

  bcb_front u_front (
    .in_ch     (in_ch),
    .square    (square),
    .push_v    (push_v),
    .push_rdy  (push_rdy),
    .push_data (push_data)
  );

  bcb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_v    (push_v),
    .push_rdy  (push_rdy),
    .push_data (push_data),
    .pop_v     (pop_v),
    .pop_rdy   (pop_rdy),
    .pop_data  (pop_data)
  );

  bcb_back #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_v    (pop_v),
    .pop_rdy  (pop_rdy),
    .pop_data (pop_data),
    .square   (square),
    .dir      (dir_r),
    .out_ch   (out_ch)
  );

endmodule

// ===== dv/bcb_letter_checker.sv =====
// letter checker: predicts cipher output from accepted bytes and compares each output word
`timescale 1ns / 100ps

module bcb_letter_checker
  import bcb_pkg::*;
#(
  parameter int BLOCK_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  bcb_in_if           in_mon,
  bcb_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [49:0] cfg_data,
  output int          fail_count,
  output int          letters_due
);

  typedef struct packed {
    logic [6:0] ch;
    logic       blk_end;
    logic       msg_end;
  } cipher_letter_t;

  cipher_letter_t letters_q[$];

  // shadow of the key square and direction
  logic [49:0] key_low;
  logic [49:0] key_mid;
  logic [24:0] key_high;
  logic        decrypt;

  pos_t        pos_buf [BLOCK_LEN];
  int          fill;
  int          fails = 0;

  function automatic logic [4:0] key_code(input int sq_idx);
    if (sq_idx < 10) return key_low[5*sq_idx +: 5];
    if (sq_idx < 20) return key_mid[5*(sq_idx-10) +: 5];
    return key_high[5*(sq_idx-20) +: 5];
  endfunction

  function automatic logic [6:0] square_letter(input int row, input int col);
    logic [4:0] code;
    code = key_code(row * 5 + col);
    if (code > LAST_CODE) return ASCII_Z;
    return ASCII_A + 7'(code);
  endfunction

  // rows of the block first, then its columns
  function automatic int split_coord(input int j, input int n);
    if (j < n) return int'(pos_buf[j].row);
    return int'(pos_buf[j-n].col);
  endfunction

  // interleaved r0,c0,r1,c1,...
  function automatic int pair_coord(input int j);
    pos_t p;
    p = pos_buf[j / 2];
    if (j % 2 == 1) return int'(p.col);
    return int'(p.row);
  endfunction

  task automatic emit_block(input logic last);
    int n;
    int r;
    int c;
    cipher_letter_t lt;
    n = fill;
    for (int k = 0; k < n; k++) begin
      if (!decrypt) begin
        r = split_coord(2*k, n);
        c = split_coord(2*k + 1, n);
      end else begin
        r = pair_coord(k);
        c = pair_coord(n + k);
      end
      lt.ch      = square_letter(r, c);
      lt.blk_end = (k + 1 == n);
      lt.msg_end = last && (k + 1 == n);
      letters_q.push_back(lt);
    end
    fill = 0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic [7:0] ch;
    logic [4:0] code;
    int hit;
    ch  = b;
    hit = -1;
    if (ch >= CHR_LOWER_A && ch <= CHR_LOWER_Z) ch = ch - CASE_GAP;
    if (ch >= CHR_UPPER_A && ch <= CHR_UPPER_Z) begin
      code = 5'(ch - CHR_UPPER_A);
      // lowest matching cell wins
      for (int c = 0; c < NUM_CELLS; c++) begin
        if (hit < 0 && key_code(c) == code) hit = c;
      end
      if (hit >= 0 && fill < BLOCK_LEN) begin
        pos_buf[fill].row = 3'(hit / 5);
        pos_buf[fill].col = 3'(hit % 5);
        fill++;
      end
    end
    if (fill >= BLOCK_LEN || (last && fill > 0)) emit_block(last);
  endtask

  task automatic check_letter();
    cipher_letter_t want;
    if (letters_q.size() == 0) begin
      $display("%0t unexpected letter: expected none actual %h", $time, out_mon.out_char);
      fails++;
    end else begin
      want = letters_q.pop_front();
      if (out_mon.out_char !== want.ch) begin
        $display("%0t out_char mismatch: expected %h actual %h", $time, want.ch,
                 out_mon.out_char);
        fails++;
      end
      if (out_mon.block_end !== want.blk_end) begin
        $display("%0t block_end mismatch: expected %b actual %b", $time, want.blk_end,
                 out_mon.block_end);
        fails++;
      end
      if (out_mon.message_end !== want.msg_end) begin
        $display("%0t message_end mismatch: expected %b actual %b", $time, want.msg_end,
                 out_mon.message_end);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_low  = '0;
      key_mid  = '0;
      key_high = '0;
      decrypt  = 1'b0;
      fill     = 0;
      letters_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SQ_LOW:  key_low  = cfg_data;
          CFG_SQ_MID:  key_mid  = cfg_data;
          CFG_SQ_HIGH: key_high = cfg_data[24:0];
          CFG_DIR:     decrypt  = cfg_data[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) check_letter();
      if (in_mon.valid && in_mon.ready) predict_byte(in_mon.char_byte, in_mon.message_last);
    end
    fail_count  <= fails;
    letters_due <= letters_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: clock, reset, key square setup, byte stimulus, output stalls and verdict
`timescale 1ns / 100ps

module tb_top;
  import bcb_pkg::*;

  localparam int BLOCK_LEN   = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 20;

  // receiver stall patterns
  localparam int SINK_OPEN    = 0;
  localparam int SINK_COIN    = 1;
  localparam int SINK_BEAT    = 2;
  localparam int SINK_TRICKLE = 3;

  typedef enum int {SQ_PERM, SQ_WILD, SQ_ZERO, SQ_ONES, SQ_DUPS} square_kind_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [49:0] cfg_data;
  logic        hold_req;
  int          fail_count;
  int          letters_due;
  int          burst_left;
  int          random_items;
  int          cycle_count;
  logic [4:0]  key_cells [NUM_CELLS];

  bcb_in_if  in_ch ();
  bcb_out_if out_ch ();

  bifid_cipher_block_top #(.BLOCK_LEN(BLOCK_LEN)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bcb_letter_checker #(.BLOCK_LEN(BLOCK_LEN)) i_letter_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .letters_due (letters_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [49:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_square(input square_kind_t kind, input logic dir);
    int order [26];
    int j;
    int t;
    logic [49:0] lo;
    logic [49:0] mid;
    logic [49:0] hi;
    for (int i = 0; i < 26; i++) order[i] = i;
    for (int i = 25; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < NUM_CELLS; i++) begin
      case (kind)
        SQ_WILD: key_cells[i] = 5'($urandom_range(0, 31));
        SQ_ZERO: key_cells[i] = 5'd0;
        SQ_ONES: key_cells[i] = 5'd31;
        default: key_cells[i] = 5'(order[i]);
      endcase
    end
    if (kind == SQ_DUPS) begin
      repeat (3) key_cells[$urandom_range(1, 24)] = key_cells[$urandom_range(0, 24)];
      key_cells[$urandom_range(0, 24)] = 5'($urandom_range(26, 31));
    end
    // junk above the register width must be dropped
    lo  = '0;
    mid = '0;
    hi  = 50'({$urandom, $urandom});
    for (int i = 0; i < 10; i++) begin
      lo[5*i +: 5]  = key_cells[i];
      mid[5*i +: 5] = key_cells[10+i];
    end
    for (int i = 0; i < 5; i++) hi[5*i +: 5] = key_cells[20+i];
    if (kind == SQ_ONES) hi = '1;
    write_reg(CFG_SQ_LOW, lo);
    write_reg(CFG_SQ_MID, mid);
    write_reg(CFG_SQ_HIGH, hi);
    write_reg(CFG_DIR, 50'({$urandom, $urandom}) & ~50'd1 | 50'(dir));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // a letter that the square holds (any letter if it holds none), random case
  function automatic logic [7:0] pick_letter();
    int codes[$];
    logic [7:0] b;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (key_cells[i] <= LAST_CODE) codes.push_back(int'(key_cells[i]));
    end
    if (codes.size() == 0) b = CHR_UPPER_A + 8'($urandom_range(0, 25));
    else b = CHR_UPPER_A + 8'(codes[$urandom_range(0, codes.size() - 1)]);
    if ($urandom_range(0, 1) == 1) b = b + CASE_GAP;
    return b;
  endfunction

  function automatic logic [7:0] non_letter();
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 63));
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.char_byte    <= b;
    in_ch.message_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_message(input int target, input bit noisy, input bit with_last);
    logic [7:0] msg[$];
    int loaded;
    loaded = 0;
    while (loaded < target) begin
      if (noisy && $urandom_range(0, 6) == 0) begin
        msg.push_back(8'($urandom_range(0, 255)));
      end else begin
        msg.push_back(pick_letter());
        loaded++;
      end
    end
    // flush on a skipped byte, or an empty message
    if (msg.size() == 0 || (with_last && noisy && $urandom_range(0, 4) == 0))
      msg.push_back(non_letter());
    foreach (msg[i]) begin
      send_byte(msg[i], with_last && (i == msg.size() - 1));
      random_items++;
    end
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (letters_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input int idx, input bit close_message);
    int phase_items;
    int r;
    int target;
    phase_items = random_items;
    if (idx == 1) begin
      // receiver stops while a long message keeps coming
      hold_req <= 1'b1;
      send_message(40, 1'b0, 1'b1);
    end
    while (random_items - phase_items < 6) begin
      r = $urandom_range(0, 11);
      if (r == 0) begin
        send_message(BLOCK_LEN, 1'b0, 1'b1);
      end else begin
        if (r == 1) target = $urandom_range(BLOCK_LEN + 1, BLOCK_LEN + 13);
        else if (r == 2) target = 0;
        else target = $urandom_range(1, 10);
        send_message(target, 1'b1, 1'b1);
      end
    end
    // leave a partial block for the next square
    if (!close_message) send_message($urandom_range(1, 5), 1'b1, 1'b0);
    wait_quiet();
  endtask

  initial begin : result_sink
    int mode;
    int span;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(SINK_OPEN, SINK_TRICKLE);
      span = $urandom_range(8, 80);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_req && !held) begin
          out_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          held = 1'b1;
        end
        case (mode)
          SINK_OPEN:    out_ch.ready <= 1'b1;
          SINK_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_BEAT:    out_ch.ready <= (k % 4 != 3);
          SINK_TRICKLE: out_ch.ready <= ($urandom_range(0, 7) == 0);
          default:      out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    square_kind_t kind;
    int phase;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.char_byte    <= 8'h00;
    in_ch.message_last <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_SQ_LOW;
    cfg_data           <= '0;
    hold_req           <= 1'b0;
    burst_left   = 8;
    random_items = 0;
    for (int i = 0; i < NUM_CELLS; i++) key_cells[i] = 5'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_square(SQ_PERM, 1'b0);
    // flush with nothing buffered
    send_byte(8'h00, 1'b1);
    send_byte(CHR_UPPER_A, 1'b0);
    send_byte(CHR_LOWER_Z, 1'b0);
    send_byte(CHR_LOWER_A, 1'b0);
    send_byte(CHR_UPPER_Z, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte(8'h7B, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(pick_letter(), 1'b0);
    send_byte(pick_letter(), 1'b1);
    // flush on a skipped byte
    send_byte(pick_letter(), 1'b0);
    send_byte(pick_letter(), 1'b0);
    send_byte(8'h20, 1'b1);
    // one-letter block
    send_byte(pick_letter(), 1'b1);
    // partial block carried across a key change
    send_byte(pick_letter(), 1'b0);
    send_byte(pick_letter(), 1'b0);
    send_byte(pick_letter(), 1'b0);
    wait_quiet();

    phase = 1;
    while (phase < 6 || random_items < 100) begin
      case (phase)
        1: kind = SQ_PERM;
        2: kind = SQ_ZERO;
        3: kind = SQ_ONES;
        4: kind = SQ_WILD;
        5: kind = SQ_DUPS;
        default: kind = square_kind_t'($urandom_range(0, 4));
      endcase
      load_square(kind, (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      run_phase(phase, (phase >= 5 && random_items >= 90) || $urandom_range(0, 2) != 0);
      phase++;
    end
    // close any partial block
    load_square(SQ_PERM, 1'($urandom_range(0, 1)));
    send_message($urandom_range(1, 8), 1'b1, 1'b1);
    wait_quiet();
    repeat (30) @(posedge clk);

    if (fail_count == 0 && letters_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
